// ===== hw/rtl/block_range_lock_table_assert.svh =====
// Assertion macros for the block range lock table.
`ifndef BLOCK_RANGE_LOCK_TABLE_ASSERT_SVH
`define BLOCK_RANGE_LOCK_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BRLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BRLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BRLT_ASSERT_NOW(lbl, ante, cons, msg)
`define BRLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/brlt_pkg.sv =====
// Shared types and codes for the block range lock table.
`default_nettype none
package brlt_pkg;

  localparam int FIRST_W    = 48;
  localparam int LAST_W     = 49;
  localparam int COUNT_W    = 32;
  localparam int HANDLE_W   = 4;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 6;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd4;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Scan token handed from one cell to the next.
  typedef struct packed {
    logic      valid;
    logic      overlap;
    logic      found;
    slot_idx_t idx;
  } scan_tok_t;

  // Write command broadcast to all cells.
  typedef struct packed {
    logic      grant;
    logic      free;
    slot_idx_t idx;
  } slot_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brlt_cell.sv =====
// One lock slot: holds a range and checks the passing scan token against it.
`default_nettype none
module brlt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  brlt_pkg::scan_tok_t          tok_in,
  output brlt_pkg::scan_tok_t                tok_out,
  input  wire  brlt_pkg::slot_cmd_t          cmd,
  input  wire  [brlt_pkg::FIRST_W-1:0]       q_first,
  input  wire  [brlt_pkg::LAST_W-1:0]        q_last,
  output logic                               held
);
  import brlt_pkg::*;

  logic [FIRST_W-1:0] first;
  logic [LAST_W-1:0]  last;
  logic               hit;
  logic               meet;
  scan_tok_t          tok_next;

  assign hit  = (cmd.idx == SLOT_IDX_W'(CELL_INDEX));
  assign meet = held && !((last < {1'b0, q_first}) || (q_last < {1'b0, first}));

  always_comb begin
    tok_next = tok_in;
    tok_next.overlap = tok_in.overlap | meet;
    if (!held && !tok_in.found) begin
      tok_next.found = 1'b1;
      tok_next.idx   = SLOT_IDX_W'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (cmd.grant && hit) begin
        held <= 1'b1;
      end else if (cmd.free && hit) begin
        held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant && hit) begin
      first <= q_first;
      last  <= q_last;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/block_range_lock_table.sv =====
// Top level of the block range lock table: command port, scan control and the cell row.
// An acquire transaction raises busy while a scan token walks the row of slot cells, one cell per
// cycle; done and the result follow in the next cycle, so a new transaction can be accepted in
// that same cycle. A release transaction is looked up directly, gives its result in the cycle
// after acceptance and never raises busy. The result is shown for one cycle only, since the
// receiver cannot stall it. The slot table is empty after reset, with no clearing pass.
`default_nettype none
module block_range_lock_table #(
  parameter int LOCK_SLOTS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                operation,
  input  wire  [brlt_pkg::FIRST_W-1:0]       start_block,
  input  wire  [brlt_pkg::COUNT_W-1:0]       block_count,
  input  wire  [brlt_pkg::HANDLE_W-1:0]      lock_handle,
  output logic                               done,
  output logic [brlt_pkg::STATUS_W-1:0]      status,
  output logic [brlt_pkg::HANDLE_W-1:0]      granted_handle
);
  import brlt_pkg::*;

  localparam int IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t             state;
  logic               launch;
  logic [FIRST_W-1:0] q_first;
  logic [LAST_W-1:0]  q_last;
  logic [COUNT_W-1:0] count_m1;
  logic [LAST_W-1:0]  last_calc;
  logic               accept;
  slot_idx_t          rel_idx;
  logic               rel_hit;
  slot_cmd_t          cmd;
  scan_tok_t          tok [LOCK_SLOTS+1];
  logic [LOCK_SLOTS-1:0] held_vec;
  logic [LOCK_SLOTS-1:0] tok_valid_vec;
  scan_tok_t          tok_end;

  assign busy     = (state == SCAN);
  assign accept   = start && !busy;
  assign count_m1 = (block_count == '0) ? '0 : (block_count - COUNT_W'(1));
  assign last_calc = {1'b0, start_block} + LAST_W'(count_m1);
  assign rel_idx  = SLOT_IDX_W'(lock_handle);
  assign rel_hit  = (int'(rel_idx) < LOCK_SLOTS) && held_vec[rel_idx[IDX_W-1:0]];
  assign tok_end  = tok[LOCK_SLOTS];

  always_comb begin
    tok[0]         = '0;
    tok[0].valid   = launch;
  end

  always_comb begin
    cmd = '0;
    if (state == IDLE && accept && operation == OP_RELEASE) begin
      cmd.free = rel_hit;
      cmd.idx  = rel_idx;
    end else if (state == SCAN && tok_end.valid) begin
      cmd.grant = !tok_end.overlap && tok_end.found;
      cmd.idx   = tok_end.idx;
    end
  end

  for (genvar i = 0; i < LOCK_SLOTS; i++) begin : g_cell
    brlt_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .cmd     (cmd),
      .q_first (q_first),
      .q_last  (q_last),
      .held    (held_vec[i])
    );
    assign tok_valid_vec[i] = tok[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (operation == OP_ACQUIRE) begin
              state  <= SCAN;
              launch <= 1'b1;
            end else begin
              done <= 1'b1;
            end
          end
        end
        SCAN: begin
          if (tok_end.valid) begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && accept) begin
      q_first <= start_block;
      q_last  <= last_calc;
      if (operation == OP_RELEASE) begin
        status         <= rel_hit ? ST_RELEASED : ST_NOT_HELD;
        granted_handle <= '0;
      end
    end else if (state == SCAN && tok_end.valid) begin
      if (tok_end.overlap) begin
        status         <= ST_BUSY;
        granted_handle <= '0;
      end else if (!tok_end.found) begin
        status         <= ST_FULL;
        granted_handle <= '0;
      end else begin
        status         <= ST_GRANTED;
        granted_handle <= HANDLE_W'(tok_end.idx);
      end
    end
  end

`include "block_range_lock_table_assert.svh"

  `BRLT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid_vec), "more than one scan token in flight")
  `BRLT_ASSERT_NOW(a_token_in_scan, tok_end.valid, state == SCAN, "scan token outside a scan")
  `BRLT_ASSERT_NEXT(a_acquire_busy, accept && operation == OP_ACQUIRE, busy, "acquire did not raise busy")
  `BRLT_ASSERT_NOW(a_handle_zero, done && status != ST_GRANTED, granted_handle == '0, "handle set without a grant")

endmodule
`default_nettype wire

// ===== dv/tb_block_range_lock_table.sv =====
// Self-checking testbench for the block range lock table: directed and random lock traffic.
module tb_block_range_lock_table;
  import brlt_pkg::*;

  localparam int LOCK_SLOTS = 16;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } lock_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                operation = OP_ACQUIRE;
  logic [FIRST_W-1:0]  start_block = '0;
  logic [COUNT_W-1:0]  block_count = '0;
  logic [HANDLE_W-1:0] lock_handle = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] granted_handle;

  logic               lock_held [LOCK_SLOTS];
  logic [FIRST_W-1:0] lock_first [LOCK_SLOTS];
  logic [LAST_W-1:0]  lock_last [LOCK_SLOTS];

  lock_reply_t pending_replies [$];
  lock_reply_t oldest_reply;
  int          fault_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  block_range_lock_table #(.LOCK_SLOTS(LOCK_SLOTS)) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .start_block    (start_block),
    .block_count    (block_count),
    .lock_handle    (lock_handle),
    .done           (done),
    .status         (status),
    .granted_handle (granted_handle)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result with no transaction outstanding: status %0d handle %0d",
               status, granted_handle);
        fault_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (status !== oldest_reply.status) begin
          $error("status: expected %0d, actual %0d", oldest_reply.status, status);
          fault_count++;
        end
        if (granted_handle !== oldest_reply.handle) begin
          $error("granted_handle: expected %0d, actual %0d", oldest_reply.handle,
                 granted_handle);
          fault_count++;
        end
      end
    end
  end

  function automatic lock_reply_t predict_lock_reply(logic op, logic [FIRST_W-1:0] first_blk,
                                                     logic [COUNT_W-1:0] count,
                                                     logic [HANDLE_W-1:0] slot);
    lock_reply_t        reply;
    logic [COUNT_W-1:0] eff_count;
    logic [LAST_W-1:0]  last_blk;
    int                 free_slot;
    logic               overlap;
    reply.status = ST_NOT_HELD;
    reply.handle = '0;
    if (op == OP_ACQUIRE) begin
      eff_count = (count == '0) ? 32'd1 : count;
      last_blk = {1'b0, first_blk} + {17'd0, eff_count} - 49'd1;
      free_slot = -1;
      overlap = 1'b0;
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        if (lock_held[i]) begin
          if (!(lock_last[i] < {1'b0, first_blk} || last_blk < {1'b0, lock_first[i]}))
            overlap = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (overlap) begin
        reply.status = ST_BUSY;
      end else if (free_slot < 0) begin
        reply.status = ST_FULL;
      end else begin
        lock_held[free_slot] = 1'b1;
        lock_first[free_slot] = first_blk;
        lock_last[free_slot] = last_blk;
        reply.status = ST_GRANTED;
        reply.handle = HANDLE_W'(free_slot);
      end
    end else if (int'(slot) < LOCK_SLOTS && lock_held[slot]) begin
      lock_held[slot] = 1'b0;
      reply.status = ST_RELEASED;
    end
    return reply;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_held_slot();
    int held_list [$];
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (lock_held[i]) held_list.push_back(i);
    if (held_list.size() == 0 || $urandom_range(0, 6) == 0)
      return HANDLE_W'($urandom_range(0, 15));
    return HANDLE_W'(held_list[$urandom_range(0, held_list.size() - 1)]);
  endfunction

  // Called right after a rising edge; returns at the edge where the transaction was accepted.
  task automatic send_request(input logic op, input logic [FIRST_W-1:0] first_blk,
                              input logic [COUNT_W-1:0] count,
                              input logic [HANDLE_W-1:0] slot);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    operation <= op;
    start_block <= first_blk;
    block_count <= count;
    lock_handle <= slot;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_lock_reply(op, first_blk, count, slot));
  endtask

  task automatic acquire_range(input logic [FIRST_W-1:0] first_blk,
                               input logic [COUNT_W-1:0] count);
    send_request(OP_ACQUIRE, first_blk, count, HANDLE_W'($urandom));
  endtask

  task automatic release_slot(input logic [HANDLE_W-1:0] slot);
    send_request(OP_RELEASE, FIRST_W'({$urandom, $urandom}), $urandom, slot);
  endtask

  task automatic test_basic_grants();
    acquire_range(48'd0, 32'd1);
    acquire_range(48'd0, 32'd1);
    acquire_range(48'd1, 32'd0);
    acquire_range(48'd2, 32'hFFFF_FFFF);
    acquire_range(48'h1_0000_0000, 32'd1);
    acquire_range(48'h1_0000_0001, 32'd1);
    release_slot(4'd1);
    release_slot(4'd1);
    acquire_range(48'd1, 32'd1);
  endtask

  task automatic test_address_top();
    acquire_range(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    acquire_range(48'hFFFF_FFFF_0000, 32'h0001_0000);
    acquire_range(48'hFFFF_FFFF_0000, 32'h0000_FFFF);
  endtask

  task automatic test_full_table();
    logic [FIRST_W-1:0] fill_base;
    fill_base = 48'h0000_1000_0000_0000;
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (!lock_held[i]) acquire_range(fill_base + FIRST_W'(8 * i), 32'd8);
    acquire_range(fill_base + 48'd3, 32'd1);
    acquire_range(48'h0000_2000_0000_0000, 32'd1);
    release_slot(4'd15);
    acquire_range(48'h0000_2000_0000_0000, 32'd1);
  endtask

  task automatic test_random_traffic(input int items, input int window, input int max_count,
                                     input int release_pct);
    logic [FIRST_W-1:0] base;
    logic [FIRST_W-1:0] first_blk;
    logic [COUNT_W-1:0] count;
    int                 pick;
    base = FIRST_W'({$urandom, $urandom});
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < release_pct) begin
        release_slot(pick_held_slot());
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 6)
          first_blk = base + FIRST_W'($urandom_range(0, window));
        else if (pick <= 8)
          first_blk = FIRST_W'({$urandom, $urandom});
        else
          first_blk = 48'hFFFF_FFFF_FFFF - FIRST_W'($urandom_range(0, 300));
        pick = $urandom_range(0, 19);
        if (pick == 0)
          count = '0;
        else if (pick == 1)
          count = $urandom;
        else if (pick == 2)
          count = 32'hFFFF_FFFF - COUNT_W'($urandom_range(0, 3));
        else
          count = COUNT_W'($urandom_range(1, max_count));
        acquire_range(first_blk, count);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      lock_held[i] = 1'b0;
      lock_first[i] = '0;
      lock_last[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_basic_grants();
    test_address_top();
    test_full_table();
    test_random_traffic(600, 64, 8, 35);
    test_random_traffic(600, 4096, 16, 30);
    test_random_traffic(500, 1 << 20, 1 << 16, 45);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (LOCK_SLOTS + 4) @(posedge clk);
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/brlt_pkg.sv
hw/rtl/brlt_cell.sv
hw/rtl/block_range_lock_table.sv
dv/tb_block_range_lock_table.sv
